FILE: rtl/i2cms_pkg.sv
// shared types and constants for the i2c master transfer sequencer
package i2cms_pkg;

    // action codes carried in the input tuser
    localparam logic [1:0] ACT_START_WR = 2'd0;
    localparam logic [1:0] ACT_START_RD = 2'd1;
    localparam logic [1:0] ACT_EVENT    = 2'd2;
    localparam logic [1:0] ACT_ERROR    = 2'd3;

    // highest error kind that is reported
    localparam logic [2:0] ERR_KIND_MAX = 3'd4;

    // status flag bit positions
    localparam int F_SB     = 0;
    localparam int F_ADDR   = 1;
    localparam int F_BTF    = 2;
    localparam int F_STOPF  = 3;
    localparam int F_TXE    = 4;
    localparam int F_RXNE   = 5;
    localparam int F_MASTER = 6;
    localparam int F_TRA    = 7;

    // notify bit positions
    localparam int N_STOP   = 0;
    localparam int N_TXDONE = 1;
    localparam int N_RXDONE = 2;
    localparam int N_SLVREQ = 3;
    localparam int N_SLVRCV = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_TX    = 2'd1,
        ST_RX    = 2'd2
    } t_state;

    typedef enum logic [2:0] {
        OP_START_WR,
        OP_START_RD,
        OP_EVENT,
        OP_ERROR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [6:0] tgt_addr;
        logic [7:0] length;
        logic       hold_bus;
        logic [7:0] status_flags;
        logic [7:0] tx_byte;
        logic [7:0] rx_byte;
        logic [2:0] error_kind;
    } t_item;

    typedef struct packed {
        logic       dr_write;
        logic [7:0] dr_value;
        logic       rx_store;
        logic [7:0] rx_index;
        logic       start_request;
        logic       stop_request;
        logic       ack_level;
        logic [1:0] busy_state;
        logic [4:0] notify_mask;
        logic [2:0] error_notice;
    } t_result;

endpackage

FILE: rtl/i2cms_front.sv
// front end: accepts input words and classifies them into queue entries
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // tgt_addr, length, hold_bus,
                                        // status_flags, tx_byte, rx_byte, error_kind
    input  logic [1:0]  s_axis_tuser,   // action
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    always_comb begin
        o_item.tgt_addr       = s_axis_tdata[6:0];
        o_item.length         = s_axis_tdata[14:7];
        o_item.hold_bus       = s_axis_tdata[15];
        o_item.status_flags   = s_axis_tdata[23:16];
        o_item.tx_byte        = s_axis_tdata[31:24];
        o_item.rx_byte        = s_axis_tdata[39:32];
        o_item.error_kind     = s_axis_tdata[42:40];
        unique case (s_axis_tuser)
            ACT_START_WR: o_item.op = OP_START_WR;
            ACT_START_RD: o_item.op = OP_START_RD;
            ACT_EVENT:    o_item.op = OP_EVENT;
            ACT_ERROR: begin
                // unknown error kinds become a no-op word
                o_item.op = (s_axis_tdata[42:40] <= ERR_KIND_MAX) ? OP_ERROR : OP_NOP;
            end
            default:      o_item.op = OP_NOP;
        endcase
    end

    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

endmodule

FILE: rtl/i2cms_queue.sv
// short queue between the front end and the execute stage
module i2cms_queue
    import i2cms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]      r_count,  n_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: rtl/i2cms_back.sv
// execute stage: transfer state, flag handling and the registered result word
module i2cms_back
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output t_result     o_result
);

    t_state     r_state,    n_state;
    logic [7:0] r_idx,      n_idx;
    logic [7:0] r_len,      n_len;
    logic [6:0] r_addr,     n_addr;
    logic       r_keep,     n_keep;
    logic       r_evt_en,   n_evt_en;
    logic       r_buf_en,   n_buf_en;
    logic       r_err_en,   n_err_en;
    logic       r_ack,      n_ack;
    logic       r_ack_en;
    logic       r_out_valid;
    t_result    r_result,   n_result;

    logic       w_master;
    logic       w_tra;
    logic [7:0] w_fl;

    assign o_pop         = i_q_valid && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign o_result      = r_result;

    assign w_fl     = i_item.status_flags;
    assign w_master = w_fl[F_MASTER];
    assign w_tra    = w_fl[F_TRA];

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_len    = r_len;
        n_addr   = r_addr;
        n_keep   = r_keep;
        n_evt_en = r_evt_en;
        n_buf_en = r_buf_en;
        n_err_en = r_err_en;
        n_ack    = r_ack;
        n_result = '0;

        if (o_pop) begin
            unique case (i_item.op)
                OP_START_WR, OP_START_RD: begin
                    if (r_state == ST_READY) begin
                        n_addr   = i_item.tgt_addr;
                        n_len    = i_item.length;
                        n_keep   = i_item.hold_bus;
                        n_idx    = '0;
                        n_state  = (i_item.op == OP_START_RD) ? ST_RX : ST_TX;
                        n_evt_en = 1'b1;
                        n_buf_en = 1'b1;
                        n_err_en = 1'b1;
                        n_result.start_request = 1'b1;
                    end
                end
                OP_EVENT: begin
                    if (r_evt_en) begin
                        if (w_fl[F_SB] && r_state != ST_READY) begin
                            n_result.dr_write = 1'b1;
                            n_result.dr_value = {r_addr, (r_state == ST_RX)};
                        end
                        if (w_fl[F_ADDR] && w_master && r_state == ST_RX && r_len == 8'd1) begin
                            n_ack = 1'b0;
                        end
                        // write done once the last byte has shifted out
                        if (w_fl[F_BTF] && w_fl[F_TXE] && r_state == ST_TX && r_idx >= r_len) begin
                            n_result.stop_request         = !r_keep;
                            n_buf_en                      = 1'b0;
                            n_evt_en                      = 1'b0;
                            n_state                       = ST_READY;
                            n_idx                         = '0;
                            n_result.notify_mask[N_TXDONE] = 1'b1;
                        end
                        if (w_fl[F_STOPF]) begin
                            n_result.notify_mask[N_STOP] = 1'b1;
                        end
                        if (w_fl[F_TXE] && r_buf_en) begin
                            if (w_master) begin
                                if (n_state == ST_TX && n_idx < r_len) begin
                                    n_result.dr_write = 1'b1;
                                    n_result.dr_value = i_item.tx_byte;
                                    n_idx             = n_idx + 8'd1;
                                end
                            end else if (w_tra) begin
                                n_result.notify_mask[N_SLVREQ] = 1'b1;
                            end
                        end
                        if (w_fl[F_RXNE] && r_buf_en) begin
                            if (w_master) begin
                                if (n_state == ST_RX && n_idx < r_len) begin
                                    // nack goes out with the last byte
                                    if (r_len > 8'd1 && (r_len - 8'd2) == n_idx) begin
                                        n_ack = 1'b0;
                                    end
                                    n_result.rx_store = 1'b1;
                                    n_result.rx_index = n_idx;
                                    n_idx             = n_idx + 8'd1;
                                    if (n_idx >= r_len) begin
                                        n_result.stop_request          = !r_keep;
                                        n_buf_en                       = 1'b0;
                                        n_evt_en                       = 1'b0;
                                        n_state                        = ST_READY;
                                        n_idx                          = '0;
                                        n_result.notify_mask[N_RXDONE] = 1'b1;
                                        if (r_ack_en) begin
                                            n_ack = 1'b1;
                                        end
                                    end
                                end
                            end else if (!w_tra) begin
                                n_result.notify_mask[N_SLVRCV] = 1'b1;
                            end
                        end
                    end
                end
                OP_ERROR: begin
                    if (r_err_en) begin
                        n_buf_en              = 1'b0;
                        n_evt_en              = 1'b0;
                        n_state               = ST_READY;
                        n_idx                 = '0;
                        n_result.stop_request = 1'b1;
                        n_result.error_notice = i_item.error_kind + 3'd1;
                    end
                end
                OP_NOP: begin
                end
                default: begin
                end
            endcase
        end

        n_result.ack_level  = n_ack;
        n_result.busy_state = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_idx       <= '0;
            r_len       <= '0;
            r_addr      <= '0;
            r_keep      <= 1'b0;
            r_evt_en    <= 1'b0;
            r_buf_en    <= 1'b0;
            r_err_en    <= 1'b0;
            r_ack       <= 1'b1;
            r_ack_en    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_len    <= n_len;
            r_addr   <= n_addr;
            r_keep   <= n_keep;
            r_evt_en <= n_evt_en;
            r_buf_en <= n_buf_en;
            r_err_en <= n_err_en;
            if (i_cfg_valid) begin
                r_ack_en <= i_cfg_data;
                r_ack    <= i_cfg_data;
            end else begin
                r_ack <= n_ack;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

FILE: rtl/i2c_master_transfer_sequencer.sv
// top level of the i2c master transfer sequencer
// Sequences one interrupt-driven I2C master write or read: start words latch the
// transfer, status event words walk the controller flags (SB, ADDR, BTF, STOPF,
// TXE, RXNE) and error words of a known kind request STOP and report the error.
// Every accepted input word gives exactly one result word. A word passes the
// classifying front end into a two-entry queue, is executed from the queue head
// into the registered output word, and one word per cycle is sustained while the
// output is not stalled. The ack_enabled register is written through i_cfg_valid/
// i_cfg_data; the user must write it only while idle, the block does not enforce it.
module i2c_master_transfer_sequencer
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // ack_enabled
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // tgt_addr, length, hold_bus,
                                         // status_flags, tx_byte, rx_byte, error_kind
    input  logic [1:0]  s_axis_tuser,    // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // dr_write, dr_value, rx_store, rx_index,
                                         // start_request, stop_request, ack_level,
                                         // busy_state, notify_mask, error_notice
);

    logic    w_push;
    logic    w_full;
    logic    w_q_valid;
    logic    w_pop;
    t_item   w_in_item;
    t_item   w_q_item;
    t_result w_result;

    assign o_cfg_ready = 1'b1;

    i2cms_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_item        (w_in_item)
    );

    i2cms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    i2cms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_result      (w_result)
    );

    assign m_axis_tdata = {1'b0,
                           w_result.error_notice,
                           w_result.notify_mask,
                           w_result.busy_state,
                           w_result.ack_level,
                           w_result.stop_request,
                           w_result.start_request,
                           w_result.rx_index,
                           w_result.rx_store,
                           w_result.dr_value,
                           w_result.dr_write};

endmodule

FILE: rtl/i2cms_checker.sv
// port-level checker for the i2c master transfer sequencer
module i2cms_checker
    import i2cms_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    a_busy_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[22:21] != 2'd3)
        else $error("busy_state out of range");

    a_dr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
        else $error("dr_value set without dr_write");

    // an error always ends the transfer with a stop request
    a_err_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[30:28] != 3'd0
            |-> m_axis_tdata[19] && m_axis_tdata[22:21] == ST_READY)
        else $error("error word without stop and ready state");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/testbench.sv
// self-checking testbench for the i2c master transfer sequencer stream block
module testbench;
    import i2cms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] FL_SB     = 8'(1 << F_SB);
    localparam logic [7:0] FL_ADDR   = 8'(1 << F_ADDR);
    localparam logic [7:0] FL_BTF    = 8'(1 << F_BTF);
    localparam logic [7:0] FL_STOPF  = 8'(1 << F_STOPF);
    localparam logic [7:0] FL_TXE    = 8'(1 << F_TXE);
    localparam logic [7:0] FL_RXNE   = 8'(1 << F_RXNE);
    localparam logic [7:0] FL_MASTER = 8'(1 << F_MASTER);
    localparam logic [7:0] FL_TRA    = 8'(1 << F_TRA);

    typedef struct {
        logic [1:0] action;
        logic [6:0] addr;
        logic [7:0] len;
        logic       rep;
        logic [7:0] flags;
        logic [7:0] tx;
        logic [7:0] rx;
        logic [2:0] kind;
    } t_xfer_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // tgt_addr, length, hold_bus,
                                      // status_flags, tx_byte, rx_byte, error_kind
    logic [1:0]  s_axis_tuser = '0;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // dr_write, dr_value, rx_store, rx_index,
                                      // start_request, stop_request, ack_level,
                                      // busy_state, notify_mask, error_notice

    i2c_master_transfer_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // sequencer state mirrored by the predictor
    t_state     seq_state = ST_READY;
    logic [7:0] seq_index = '0;
    logic [7:0] seq_length = '0;
    logic [6:0] seq_addr = '0;
    logic       seq_keep_bus = 1'b0;
    logic       seq_ev_ien = 1'b0;
    logic       seq_buf_ien = 1'b0;
    logic       seq_err_ien = 1'b0;
    logic       seq_ack_bit = 1'b1;
    logic       seq_ack_enable = 1'b1;

    t_xfer_word pending_words[$];
    t_result    expected_results[$];
    t_xfer_word cur_word;
    int         fail_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_off_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void close_transfer(input logic was_read);
        seq_buf_ien = 1'b0;
        seq_ev_ien = 1'b0;
        seq_state = ST_READY;
        seq_index = '0;
        if (was_read && seq_ack_enable) begin
            seq_ack_bit = 1'b1;
        end
    endfunction

    function automatic t_result predict_sequencer(input t_xfer_word w);
        t_result r;
        logic buffer_on;
        logic mst;
        logic tra;
        r = '0;
        case (w.action)
            ACT_START_WR, ACT_START_RD: begin
                if (seq_state == ST_READY) begin
                    seq_addr = w.addr;
                    seq_length = w.len;
                    seq_keep_bus = w.rep;
                    seq_index = '0;
                    seq_state = (w.action == ACT_START_WR) ? ST_TX : ST_RX;
                    r.start_request = 1'b1;
                    seq_ev_ien = 1'b1;
                    seq_buf_ien = 1'b1;
                    seq_err_ien = 1'b1;
                end
            end
            ACT_EVENT: begin
                if (seq_ev_ien) begin
                    // buffer enable is taken once, before any flag can close the transfer
                    buffer_on = seq_buf_ien;
                    mst = w.flags[F_MASTER];
                    tra = w.flags[F_TRA];
                    if (w.flags[F_SB] && seq_state != ST_READY) begin
                        r.dr_write = 1'b1;
                        r.dr_value = {seq_addr, seq_state == ST_RX};
                    end
                    if (w.flags[F_ADDR] && mst && seq_state == ST_RX && seq_length == 8'd1) begin
                        seq_ack_bit = 1'b0;
                    end
                    if (w.flags[F_BTF] && w.flags[F_TXE] && seq_state == ST_TX &&
                        seq_index >= seq_length) begin
                        if (!seq_keep_bus) begin
                            r.stop_request = 1'b1;
                        end
                        close_transfer(1'b0);
                        r.notify_mask[N_TXDONE] = 1'b1;
                    end
                    if (w.flags[F_STOPF]) begin
                        r.notify_mask[N_STOP] = 1'b1;
                    end
                    if (w.flags[F_TXE] && buffer_on) begin
                        if (mst) begin
                            if (seq_state == ST_TX && seq_index < seq_length) begin
                                r.dr_write = 1'b1;
                                r.dr_value = w.tx;
                                seq_index = seq_index + 8'd1;
                            end
                        end else if (tra) begin
                            r.notify_mask[N_SLVREQ] = 1'b1;
                        end
                    end
                    if (w.flags[F_RXNE] && buffer_on) begin
                        if (mst) begin
                            if (seq_state == ST_RX && seq_index < seq_length) begin
                                if (seq_length > 8'd1 && seq_length - 8'd2 == seq_index) begin
                                    seq_ack_bit = 1'b0;
                                end
                                r.rx_store = 1'b1;
                                r.rx_index = seq_index;
                                seq_index = seq_index + 8'd1;
                                if (seq_index >= seq_length) begin
                                    if (!seq_keep_bus) begin
                                        r.stop_request = 1'b1;
                                    end
                                    close_transfer(1'b1);
                                    r.notify_mask[N_RXDONE] = 1'b1;
                                end
                            end
                        end else if (!tra) begin
                            r.notify_mask[N_SLVRCV] = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (seq_err_ien && w.kind <= ERR_KIND_MAX) begin
                    close_transfer(1'b0);
                    r.stop_request = 1'b1;
                    r.error_notice = w.kind + 3'd1;
                end
            end
        endcase
        r.ack_level = seq_ack_bit;
        r.busy_state = seq_state;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result(input logic [31:0] d);
        t_result want;
        if (expected_results.size() == 0) begin
            $error("result word with nothing expected: %h", d);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("dr_write", want.dr_write, d[0]);
            check_field("dr_value", want.dr_value, d[8:1]);
            check_field("rx_store", want.rx_store, d[9]);
            check_field("rx_index", want.rx_index, d[17:10]);
            check_field("start_request", want.start_request, d[18]);
            check_field("stop_request", want.stop_request, d[19]);
            check_field("ack_level", want.ack_level, d[20]);
            check_field("busy_state", want.busy_state, d[22:21]);
            check_field("notify_mask", want.notify_mask, d[27:23]);
            check_field("error_notice", want.error_notice, d[30:28]);
        end
    endfunction

    // input side: predict on acceptance, then offer the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_sequencer(cur_word));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= cur_word.action;
                    s_axis_tdata <= {5'd0, cur_word.kind, cur_word.rx, cur_word.tx,
                                     cur_word.flags, cur_word.rep, cur_word.len, cur_word.addr};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: check each accepted word, stall at random or for a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_xfer_word random_word();
        t_xfer_word w;
        w.action = 2'($urandom_range(3));
        w.addr = 7'($urandom_range(127));
        w.len = 8'($urandom_range(255));
        w.rep = 1'($urandom_range(1));
        w.flags = 8'($urandom_range(255));
        w.tx = 8'($urandom_range(255));
        w.rx = 8'($urandom_range(255));
        w.kind = 3'($urandom_range(7));
        return w;
    endfunction

    function automatic void add_start(input logic [1:0] act, input logic [6:0] a,
                                      input logic [7:0] n, input logic r);
        t_xfer_word w;
        w = random_word();
        w.action = act;
        w.addr = a;
        w.len = n;
        w.rep = r;
        pending_words.push_back(w);
    endfunction

    function automatic void add_event(input logic [7:0] fl, input logic [7:0] tx,
                                      input logic [7:0] rx);
        t_xfer_word w;
        w = random_word();
        w.action = ACT_EVENT;
        w.flags = fl;
        w.tx = tx;
        w.rx = rx;
        pending_words.push_back(w);
    endfunction

    function automatic void add_error(input logic [2:0] k);
        t_xfer_word w;
        w = random_word();
        w.action = ACT_ERROR;
        w.kind = k;
        pending_words.push_back(w);
    endfunction

    // one well-formed write or read with random content, sometimes cut short
    function automatic int add_transfer();
        logic       rd;
        logic [7:0] n;
        logic [7:0] base;
        logic [7:0] extra;
        int         added;
        int         cut;
        rd = 1'($urandom_range(1));
        n = ($urandom_range(99) < 3) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
        base = rd ? FL_MASTER : (FL_MASTER | FL_TRA);
        add_start(rd ? ACT_START_RD : ACT_START_WR, 7'($urandom_range(127)), n,
                  1'($urandom_range(1)));
        add_event(base | FL_SB, 8'($urandom), 8'($urandom));
        add_event(base | FL_ADDR, 8'($urandom), 8'($urandom));
        added = 3 + n;
        for (int i = 0; i < n; i++) begin
            extra = ($urandom_range(9) == 0) ? (FL_STOPF | FL_BTF) : 8'd0;
            add_event(base | extra | (rd ? FL_RXNE : FL_TXE), 8'($urandom), 8'($urandom));
        end
        if (!rd) begin
            extra = ($urandom_range(3) == 0) ? FL_STOPF : 8'd0;
            add_event(base | extra | FL_BTF | FL_TXE, 8'($urandom), 8'($urandom));
            added++;
        end else if (n == 0) begin
            // a zero-length read never finishes on its own
            add_error(3'($urandom_range(4)));
            added++;
        end
        if ($urandom_range(99) < 12) begin
            cut = $urandom_range(added - 1, 1);
            repeat (cut) void'(pending_words.pop_back());
            added -= cut;
            if ($urandom_range(1) == 1) begin
                add_error(3'($urandom_range(4)));
                added++;
            end
        end
        return added;
    endfunction

    task automatic run_random(input int send_pct, input int recv_pct, input int target);
        int count;
        count = 0;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        while (count < target) begin
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(3, 1)) pending_words.push_back(random_word());
            end else begin
                count += add_transfer();
            end
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_ack_enable(input logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        seq_ack_enable = v;
        seq_ack_bit = v;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_ack_enable(1'b1);

        // events and errors before any start are ignored
        add_event(8'hFF, 8'hFF, 8'hFF);
        add_error(3'd0);
        // write of two bytes, a start while busy, address and data together
        add_start(ACT_START_WR, 7'h7F, 8'd2, 1'b0);
        add_start(ACT_START_RD, 7'h00, 8'd255, 1'b1);
        add_event(FL_SB | FL_MASTER | FL_TRA, 8'h00, 8'h00);
        add_event(FL_ADDR | FL_MASTER | FL_TRA, 8'h00, 8'h00);
        add_event(FL_TXE | FL_MASTER | FL_TRA, 8'hFF, 8'h00);
        add_event(FL_SB | FL_TXE | FL_MASTER | FL_TRA, 8'h00, 8'hFF);
        add_event(FL_BTF | FL_TXE | FL_STOPF | FL_MASTER | FL_TRA, 8'hA5, 8'h5A);
        // one-byte read keeping the bus
        add_start(ACT_START_RD, 7'h55, 8'd1, 1'b1);
        add_event(FL_SB | FL_MASTER, 8'h00, 8'h00);
        add_event(FL_ADDR | FL_MASTER, 8'h00, 8'h00);
        add_event(FL_RXNE | FL_MASTER, 8'h00, 8'hFF);
        // three-byte read, ack dropped before the last byte
        add_start(ACT_START_RD, 7'h01, 8'd3, 1'b0);
        add_event(FL_RXNE | FL_MASTER, 8'h00, 8'h00);
        add_event(FL_RXNE | FL_MASTER, 8'h00, 8'h3C);
        add_event(FL_RXNE | FL_MASTER, 8'h00, 8'hC3);
        // zero-length write finishes on the first btf with txe
        add_start(ACT_START_WR, 7'h2A, 8'd0, 1'b1);
        add_event(FL_BTF | FL_TXE | FL_MASTER | FL_TRA, 8'h11, 8'h22);
        // zero-length read, slave notices, then errors
        add_start(ACT_START_RD, 7'h40, 8'd0, 1'b0);
        add_event(FL_TXE | FL_TRA, 8'h00, 8'h00);
        add_event(FL_RXNE, 8'h00, 8'h00);
        add_error(3'd7);
        add_error(3'd4);
        add_error(3'd2);
        drain();

        // long output stall while words keep coming
        @(negedge i_clk);
        hold_off_cycles = 300;
        run_random(0, 0, 475);
        drain();
        write_ack_enable(1'b0);
        run_random(57, 0, 475);
        drain();
        write_ack_enable(1'b1);
        run_random(0, 57, 475);
        drain();
        write_ack_enable(1'b0);
        run_random(15, 15, 475);
        drain();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
